// ----- rtl/mpa_pkg.sv -----
// Shared constants, types and row helpers for the multi-pattern automaton.
package mpa_pkg;

   localparam int MAX_NODES  = 4096;
   localparam int ALPHABET   = 10;
   localparam int NODE_W     = $clog2(MAX_NODES);
   localparam int CNT_W      = NODE_W + 1;
   localparam int SYM_W      = $clog2(ALPHABET);
   localparam int ROW_W      = ALPHABET * NODE_W;
   localparam int QENT_W     = 2 * NODE_W;
   localparam int SYMBOL_W   = 4;
   localparam int NODE_OUT_W = 12;
   localparam int STATUS_W   = 2;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [ROW_W-1:0]  row_type;

   typedef struct packed {
      node_type node;
      node_type fail;
   } qent_type;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_BUILD  = 2'd1,
      REQ_STEP   = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_DROPPED = 2'd1,
      STAT_UNBUILT = 2'd2
   } status_type;

   typedef enum logic [12:0] {
      S_CLR      = 13'b0000000000001,
      S_IDLE     = 13'b0000000000010,
      S_INS_RD   = 13'b0000000000100,
      S_INS_MK   = 13'b0000000001000,
      S_STEP_RD  = 13'b0000000010000,
      S_STEP_MK  = 13'b0000000100000,
      S_BLD_ROOT = 13'b0000001000000,
      S_BLD_ENQ  = 13'b0000010000000,
      S_BLD_POP  = 13'b0000100000000,
      S_BLD_RDU  = 13'b0001000000000,
      S_BLD_RDF  = 13'b0010000000000,
      S_BLD_MRG  = 13'b0100000000000,
      S_DONE     = 13'b1000000000000
   } state_type;

   function automatic node_type row_get(input row_type row, input logic [SYM_W-1:0] idx);
      return row[NODE_W*idx +: NODE_W];
   endfunction

   function automatic row_type row_set(input row_type row, input logic [SYM_W-1:0] idx,
                                       input node_type val);
      row_type r;
      r = row;
      r[NODE_W*idx +: NODE_W] = val;
      return r;
   endfunction

   function automatic row_type row_fill(input row_type rowu, input row_type rowf);
      row_type r;
      for (int i = 0; i < ALPHABET; i++) begin
         if (rowu[NODE_W*i +: NODE_W] == '0) begin
            r[NODE_W*i +: NODE_W] = rowf[NODE_W*i +: NODE_W];
         end else begin
            r[NODE_W*i +: NODE_W] = rowu[NODE_W*i +: NODE_W];
         end
      end
      return r;
   endfunction

endpackage

// ----- rtl/mpa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module mpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ----- rtl/multi_pattern_automaton.sv -----
// Top level: request sequencer over the goto, mark and walk-queue memories.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_type, req_symbol, req_pattern_end,
//                                              req_restart
//   rsp      out        rsp_valid / rsp_ready  rsp_node_index, rsp_matched, rsp_status
//
// Insert: one goto row read, plus a mark read when it follows an existing edge mid-pattern.
// Match step: one goto row read, one mark read (none before build). Build per node: pop, read
// its row, read its fail row, merge, queue its children. Reset and clear run a pass over all
// MAX_NODES goto and mark entries; no item is taken during it.
// A result waits in the output register; the sequencer holds in S_DONE while it is full.
module multi_pattern_automaton (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_type,
   input  logic [mpa_pkg::SYMBOL_W-1:0]        req_symbol,
   input  logic                                req_pattern_end,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mpa_pkg::NODE_OUT_W-1:0]      rsp_node_index,
   output logic                                rsp_matched,
   output logic [mpa_pkg::STATUS_W-1:0]        rsp_status
);

   mpa_pkg::state_type    state_ff, state_in;
   mpa_pkg::req_code_type code_in;
   logic [mpa_pkg::SYM_W-1:0]  sym_ff, sym_in, idx_ff, idx_in;
   logic                       pend_ff, pend_in;
   mpa_pkg::node_type          cursor_ff, cursor_in, match_ff, match_in;
   mpa_pkg::node_type          qu_ff, qu_in, qf_ff, qf_in, clr_addr_ff, clr_addr_in;
   logic [mpa_pkg::CNT_W-1:0]  count_ff, count_in, head_ff, head_in, tail_ff, tail_in;
   logic                       built_ff, built_in, clr_rsp_ff, clr_rsp_in, mf_ff, mf_in;
   mpa_pkg::row_type           rowu_ff, rowu_in, rowf_ff, rowf_in;
   mpa_pkg::node_type          res_node_ff, res_node_in;
   logic                       res_mark_ff, res_mark_in;
   mpa_pkg::status_type        res_stat_ff, res_stat_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [mpa_pkg::NODE_OUT_W-1:0] rsp_node_ff, rsp_node_in;
   logic                       rsp_mark_ff, rsp_mark_in;
   logic [mpa_pkg::STATUS_W-1:0] rsp_stat_ff, rsp_stat_in;

   logic                g_we;
   mpa_pkg::node_type   g_wa, g_ra;
   mpa_pkg::row_type    g_wd, g_rd;
   logic                m_we;
   mpa_pkg::node_type   m_wa, m_ra;
   logic [0:0]          m_wd, m_rd;
   logic                q_we;
   mpa_pkg::node_type   q_wa;
   mpa_pkg::qent_type   q_wd, q_rd;

   logic [mpa_pkg::SYM_W-1:0] sym_sat;
   mpa_pkg::node_type         e, v, eff;

   function automatic mpa_pkg::node_type row_get_w(input mpa_pkg::row_type row,
                                                   input logic [mpa_pkg::SYM_W-1:0] idx);
      return mpa_pkg::row_get(row, idx);
   endfunction

   mpa_ram #(.WIDTH(mpa_pkg::ROW_W), .DEPTH(mpa_pkg::MAX_NODES)) u_goto (
      .clock(clock), .wr_en(g_we), .wr_addr(g_wa), .wr_data(g_wd),
      .rd_addr(g_ra), .rd_data_ff(g_rd)
   );

   mpa_ram #(.WIDTH(1), .DEPTH(mpa_pkg::MAX_NODES)) u_mark (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data_ff(m_rd)
   );

   mpa_ram #(.WIDTH(mpa_pkg::QENT_W), .DEPTH(mpa_pkg::MAX_NODES)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(head_ff[mpa_pkg::NODE_W-1:0]), .rd_data_ff(q_rd)
   );

   assign req_ready      = (state_ff == mpa_pkg::S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_node_index = rsp_node_ff;
   assign rsp_matched    = rsp_mark_ff;
   assign rsp_status     = rsp_stat_ff;

   assign code_in = mpa_pkg::req_code_type'(req_type);
   assign sym_sat = (req_symbol >= mpa_pkg::SYMBOL_W'(mpa_pkg::ALPHABET)) ?
                    mpa_pkg::SYM_W'(mpa_pkg::ALPHABET - 1) : mpa_pkg::SYM_W'(req_symbol);
   assign eff     = req_restart ? '0 : match_ff;

   always_comb begin
      state_in    = state_ff;
      sym_in      = sym_ff;
      pend_in     = pend_ff;
      idx_in      = idx_ff;
      cursor_in   = cursor_ff;
      match_in    = match_ff;
      qu_in       = qu_ff;
      qf_in       = qf_ff;
      clr_addr_in = clr_addr_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      built_in    = built_ff;
      clr_rsp_in  = clr_rsp_ff;
      mf_in       = mf_ff;
      rowu_in     = rowu_ff;
      rowf_in     = rowf_ff;
      res_node_in = res_node_ff;
      res_mark_in = res_mark_ff;
      res_stat_in = res_stat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_node_in = rsp_node_ff;
      rsp_mark_in = rsp_mark_ff;
      rsp_stat_in = rsp_stat_ff;
      g_we = 1'b0;
      g_wa = cursor_ff;
      g_wd = '0;
      g_ra = cursor_ff;
      m_we = 1'b0;
      m_wa = qu_ff;
      m_wd = '0;
      m_ra = qu_ff;
      q_we = 1'b0;
      q_wa = tail_ff[mpa_pkg::NODE_W-1:0];
      q_wd = '0;
      e    = row_get_w(g_rd, sym_ff);
      v    = e;

      unique case (state_ff)
         mpa_pkg::S_CLR: begin
            g_we = 1'b1;
            g_wa = clr_addr_ff;
            m_we = 1'b1;
            m_wa = clr_addr_ff;
            if (clr_addr_ff == mpa_pkg::NODE_W'(mpa_pkg::MAX_NODES - 1)) begin
               res_node_in = '0;
               res_mark_in = 1'b0;
               res_stat_in = mpa_pkg::STAT_OK;
               state_in = clr_rsp_ff ? mpa_pkg::S_DONE : mpa_pkg::S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         mpa_pkg::S_IDLE: begin
            if (code_in == mpa_pkg::REQ_STEP) begin
               g_ra = eff;
            end else if (code_in == mpa_pkg::REQ_BUILD) begin
               g_ra = '0;
            end
            if (req_valid) begin
               sym_in = sym_sat;
               pend_in = req_pattern_end;
               res_node_in = '0;
               res_mark_in = 1'b0;
               res_stat_in = mpa_pkg::STAT_OK;
               unique case (code_in)
                  mpa_pkg::REQ_INSERT: state_in = mpa_pkg::S_INS_RD;
                  mpa_pkg::REQ_BUILD: begin
                     head_in = '0;
                     tail_in = '0;
                     state_in = built_ff ? mpa_pkg::S_DONE : mpa_pkg::S_BLD_ROOT;
                  end
                  mpa_pkg::REQ_STEP: begin
                     match_in = eff;
                     if (!built_ff) begin
                        res_node_in = eff;
                        res_stat_in = mpa_pkg::STAT_UNBUILT;
                        state_in = mpa_pkg::S_DONE;
                     end else begin
                        state_in = mpa_pkg::S_STEP_RD;
                     end
                  end
                  mpa_pkg::REQ_CLEAR: begin
                     count_in = '0;
                     cursor_in = '0;
                     match_in = '0;
                     built_in = 1'b0;
                     clr_addr_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in = mpa_pkg::S_CLR;
                  end
                  default: state_in = mpa_pkg::S_IDLE;
               endcase
            end
         end
         mpa_pkg::S_INS_RD: begin
            res_stat_in = mpa_pkg::STAT_OK;
            state_in = mpa_pkg::S_DONE;
            if (built_ff || (e == '0 &&
                !((count_ff + 1'b1) < mpa_pkg::CNT_W'(mpa_pkg::MAX_NODES)))) begin
               res_node_in = cursor_ff;
               res_mark_in = 1'b0;
               res_stat_in = mpa_pkg::STAT_DROPPED;
               if (pend_ff) begin
                  cursor_in = '0;
               end
            end else begin
               if (e == '0) begin
                  v = mpa_pkg::NODE_W'(count_ff + 1'b1);
                  count_in = count_ff + 1'b1;
                  g_we = 1'b1;
                  g_wa = cursor_ff;
                  g_wd = mpa_pkg::row_set(g_rd, sym_ff, v);
               end
               res_node_in = v;
               res_mark_in = 1'b0;
               m_ra = v;
               if (pend_ff) begin
                  m_we = 1'b1;
                  m_wa = v;
                  m_wd = 1'b1;
                  res_mark_in = 1'b1;
                  cursor_in = '0;
               end else begin
                  cursor_in = v;
                  if (e != '0) begin
                     state_in = mpa_pkg::S_INS_MK;
                  end
               end
            end
         end
         mpa_pkg::S_INS_MK: begin
            res_mark_in = m_rd[0];
            state_in = mpa_pkg::S_DONE;
         end
         mpa_pkg::S_STEP_RD: begin
            match_in = e;
            m_ra = e;
            res_node_in = e;
            res_stat_in = mpa_pkg::STAT_OK;
            state_in = mpa_pkg::S_STEP_MK;
         end
         mpa_pkg::S_STEP_MK: begin
            res_mark_in = m_rd[0];
            state_in = mpa_pkg::S_DONE;
         end
         mpa_pkg::S_BLD_ROOT: begin
            rowu_in = g_rd;
            rowf_in = '0;
            idx_in = '0;
            state_in = mpa_pkg::S_BLD_ENQ;
         end
         mpa_pkg::S_BLD_ENQ: begin
            if (row_get_w(rowu_ff, idx_ff) != '0 &&
                tail_ff < mpa_pkg::CNT_W'(mpa_pkg::MAX_NODES)) begin
               q_we = 1'b1;
               q_wd.node = row_get_w(rowu_ff, idx_ff);
               q_wd.fail = row_get_w(rowf_ff, idx_ff);
               tail_in = tail_ff + 1'b1;
            end
            if (idx_ff == mpa_pkg::SYM_W'(mpa_pkg::ALPHABET - 1)) begin
               state_in = mpa_pkg::S_BLD_POP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         mpa_pkg::S_BLD_POP: begin
            if (head_ff == tail_ff) begin
               built_in = 1'b1;
               state_in = mpa_pkg::S_DONE;
            end else begin
               head_in = head_ff + 1'b1;
               state_in = mpa_pkg::S_BLD_RDU;
            end
         end
         mpa_pkg::S_BLD_RDU: begin
            qu_in = q_rd.node;
            qf_in = q_rd.fail;
            g_ra = q_rd.node;
            m_ra = q_rd.fail;
            state_in = mpa_pkg::S_BLD_RDF;
         end
         mpa_pkg::S_BLD_RDF: begin
            rowu_in = g_rd;
            mf_in = m_rd[0];
            g_ra = qf_ff;
            m_ra = qu_ff;
            state_in = mpa_pkg::S_BLD_MRG;
         end
         mpa_pkg::S_BLD_MRG: begin
            rowf_in = g_rd;
            g_we = 1'b1;
            g_wa = qu_ff;
            g_wd = mpa_pkg::row_fill(rowu_ff, g_rd);
            m_we = 1'b1;
            m_wa = qu_ff;
            m_wd = m_rd | mf_ff;
            idx_in = '0;
            state_in = mpa_pkg::S_BLD_ENQ;
         end
         mpa_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_node_in = mpa_pkg::NODE_OUT_W'(res_node_ff);
               rsp_mark_in = res_mark_ff;
               rsp_stat_in = res_stat_ff;
               state_in = mpa_pkg::S_IDLE;
            end
         end
         default: state_in = mpa_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpa_pkg::S_CLR;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         count_ff     <= '0;
         cursor_ff    <= '0;
         match_ff     <= '0;
         built_ff     <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         match_ff     <= match_in;
         built_ff     <= built_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      pend_ff     <= pend_in;
      qu_ff       <= qu_in;
      qf_ff       <= qf_in;
      mf_ff       <= mf_in;
      rowu_ff     <= rowu_in;
      rowf_ff     <= rowf_in;
      res_node_ff <= res_node_in;
      res_mark_ff <= res_mark_in;
      res_stat_ff <= res_stat_in;
      rsp_node_ff <= rsp_node_in;
      rsp_mark_ff <= rsp_mark_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < mpa_pkg::CNT_W'(mpa_pkg::MAX_NODES))
      else $error("node count out of range");

   a_cursor_alloc: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cursor_ff} <= count_ff)
      else $error("insert cursor beyond allocated nodes");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("walk queue head passed tail");

   a_build_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mpa_pkg::S_BLD_POP && head_ff == tail_ff) |=> built_ff)
      else $error("build finished without setting built flag");

endmodule

// ----- test/tb_multi_pattern_automaton.sv -----
// Testbench for the multi-pattern automaton: random and directed items against a trie model.
`timescale 1ns / 100ps

module tb_multi_pattern_automaton;

   localparam int NODES = 4096;
   localparam int SYMS  = 10;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic [11:0] node;
      logic        mark;
      logic [1:0]  status;
   } match_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_type = mpa_pkg::REQ_INSERT;
   logic [3:0] req_symbol = '0;
   logic req_pattern_end = 1'b0;
   logic req_restart = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [11:0] rsp_node_index;
   logic rsp_matched;
   logic [1:0] rsp_status;

   multi_pattern_automaton u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // trie model
   int unsigned trie_goto [NODES][SYMS];
   int unsigned trie_fail [NODES];
   logic        trie_mark [NODES];
   int unsigned bfs_order [NODES];
   int unsigned trie_count, ins_cursor, walk_state;
   bit          trie_built;

   match_result_type pending_results[$];
   int unsigned   error_count = 0, result_count = 0, item_count = 0, match_hits = 0;
   bit            idle_enable = 1'b1;
   bit            hold_active = 1'b0;
   event          hold_off_go;

   task automatic trie_clear();
      for (int n = 0; n < NODES; n++) begin
         for (int s = 0; s < SYMS; s++) trie_goto[n][s] = 0;
         trie_fail[n] = 0;
         trie_mark[n] = 1'b0;
      end
      trie_count = 0;
      ins_cursor = 0;
      walk_state = 0;
      trie_built = 1'b0;
   endtask

   task automatic trie_build();
      int unsigned head, tail, u, f, v;
      head = 0;
      tail = 0;
      for (int s = 0; s < SYMS; s++) begin
         v = trie_goto[0][s];
         if (v != 0 && tail < NODES) begin
            trie_fail[v] = 0;
            bfs_order[tail++] = v;
         end
      end
      while (head < tail) begin
         u = bfs_order[head++];
         f = trie_fail[u];
         trie_mark[u] = trie_mark[u] | trie_mark[f];
         for (int s = 0; s < SYMS; s++) begin
            v = trie_goto[u][s];
            if (v == 0) begin
               trie_goto[u][s] = trie_goto[f][s];
            end else if (tail < NODES) begin
               trie_fail[v] = trie_goto[f][s];
               bfs_order[tail++] = v;
            end
         end
      end
      trie_built = 1'b1;
   endtask

   task automatic trie_apply(input logic [1:0] kind, input logic [3:0] sym_in,
                             input logic pend, input logic rst);
      match_result_type r;
      int unsigned sym, u, v;
      r = '0;
      sym = (32'(sym_in) >= SYMS) ? SYMS - 1 : 32'(sym_in);
      case (kind)
         mpa_pkg::REQ_INSERT: begin
            u = ins_cursor;
            v = trie_goto[u][sym];
            if (!trie_built && v == 0 && trie_count + 1 < NODES) begin
               trie_count++;
               v = trie_count;
               trie_goto[u][sym] = v;
            end
            if (trie_built || v == 0) begin
               r.node = 12'(u);
               r.status = mpa_pkg::STAT_DROPPED;
               if (pend) ins_cursor = 0;
            end else begin
               if (pend) begin
                  trie_mark[v] = 1'b1;
                  ins_cursor = 0;
               end else begin
                  ins_cursor = v;
               end
               r.node = 12'(v);
               r.mark = trie_mark[v];
            end
         end
         mpa_pkg::REQ_BUILD: if (!trie_built) trie_build();
         mpa_pkg::REQ_STEP: begin
            if (rst) walk_state = 0;
            if (!trie_built) begin
               r.node = 12'(walk_state);
               r.status = mpa_pkg::STAT_UNBUILT;
            end else begin
               walk_state = trie_goto[walk_state][sym];
               r.node = 12'(walk_state);
               r.mark = trie_mark[walk_state];
            end
         end
         default: trie_clear();
      endcase
      pending_results.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic send_item(input logic [1:0] kind, input logic [3:0] sym,
                            input logic pend, input logic rst);
      while (idle_enable && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_symbol <= sym;
      req_pattern_end <= pend;
      req_restart <= rst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      trie_apply(kind, sym, pend, rst);
      item_count++;
      @(negedge clock);
   endtask

   // result side
   always begin
      @(hold_off_go);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_active = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_active) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_enable && $urandom_range(99) < 14);
      end
   end

   always @(posedge clock) begin
      match_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result node", 32'(rsp_node_index), 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_node_index !== want.node)
               report_mismatch("node_index", 32'(rsp_node_index), 32'(want.node));
            if (rsp_matched !== want.mark)
               report_mismatch("matched", 32'(rsp_matched), 32'(want.mark));
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (want.mark) match_hits++;
         end
      end
   end

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic insert_pattern(input int unsigned len);
      for (int i = 0; i < len; i++)
         send_item(mpa_pkg::REQ_INSERT, 4'($urandom_range(3)), i == len - 1,
                   1'($urandom_range(1)));
   endtask

   task automatic test_directed();
      send_item(mpa_pkg::REQ_STEP, 4'd5, 1'b0, 1'b0);
      send_item(mpa_pkg::REQ_STEP, 4'd5, 1'b0, 1'b1);
      send_item(mpa_pkg::REQ_INSERT, 4'd0, 1'b0, 1'b0);
      send_item(mpa_pkg::REQ_INSERT, 4'd15, 1'b0, 1'b1);
      send_item(mpa_pkg::REQ_INSERT, 4'd9, 1'b1, 1'b0);
      send_item(mpa_pkg::REQ_INSERT, 4'd9, 1'b1, 1'b0);
      send_item(mpa_pkg::REQ_INSERT, 4'd12, 1'b1, 1'b0);
      send_item(mpa_pkg::REQ_BUILD, 4'd0, 1'b0, 1'b0);
      send_item(mpa_pkg::REQ_BUILD, 4'd3, 1'b1, 1'b1);
      send_item(mpa_pkg::REQ_INSERT, 4'd1, 1'b1, 1'b0);
      send_item(mpa_pkg::REQ_STEP, 4'd0, 1'b0, 1'b1);
      send_item(mpa_pkg::REQ_STEP, 4'd9, 1'b0, 1'b0);
      send_item(mpa_pkg::REQ_STEP, 4'd10, 1'b1, 1'b0);
      send_item(mpa_pkg::REQ_STEP, 4'd15, 1'b0, 1'b0);
      send_item(mpa_pkg::REQ_STEP, 4'd9, 1'b0, 1'b1);
      send_item(mpa_pkg::REQ_CLEAR, 4'd7, 1'b1, 1'b1);
      send_item(mpa_pkg::REQ_STEP, 4'd1, 1'b0, 1'b0);
      drain();
   endtask

   task automatic test_random_rounds();
      int unsigned steps;
      for (int round = 0; round < 12; round++) begin
         idle_enable = (round != 3);
         for (int p = 0; p < 5; p++) insert_pattern($urandom_range(1, 4));
         if ($urandom_range(3) == 0)
            send_item(mpa_pkg::REQ_STEP, 4'($urandom_range(15)), 1'b0, 1'b1);
         send_item(mpa_pkg::REQ_BUILD, 4'($urandom_range(15)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
         if (round == 2) -> hold_off_go;
         steps = 30;
         for (int i = 0; i < steps; i++) begin
            if ($urandom_range(19) == 0)
               send_item(mpa_pkg::REQ_INSERT, 4'($urandom_range(15)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
            else
               send_item(mpa_pkg::REQ_STEP, ($urandom_range(9) == 0) ?
                         4'($urandom_range(10, 15)) : 4'($urandom_range(3)),
                         1'b0, $urandom_range(15) == 0);
         end
         if (round == 5) drain();
         send_item(mpa_pkg::REQ_CLEAR, 4'($urandom_range(15)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
      end
      idle_enable = 1'b1;
      drain();
   endtask

   initial begin
      trie_clear();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_rounds();
      repeat (20) @(posedge clock);
      $display("Covered %0d items, %0d results, %0d pattern hits.",
               item_count, result_count, match_hits);
      $display("Inserts, builds, steps and clears ran with idling, a long stall and a drain.");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
